// File: design/sliding_window_min_max_average_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sliding window min/max/average block
// Each macro expands to a concurrent assertion on clk with rst_n as disable.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_AVERAGE_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_AVERAGE_ASSERT_SVH

`ifndef ASSERT_OFF
// Condition must hold at every clock edge out of reset.
`define SWMMA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent in this cycle implies consequent in this cycle.
`define SWMMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Antecedent in this cycle implies consequent in the next cycle.
`define SWMMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SWMMA_ASSERT(lbl, cond, msg)
`define SWMMA_ASSERT_IMP(lbl, ante, cons, msg)
`define SWMMA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/swmma_pkg.sv
// ---------------------------------------------------------------------------
// swmma_pkg
// Shared widths and defaults for the sliding window min/max/average block.
// ---------------------------------------------------------------------------
package swmma_pkg;

  // Default history depth
  localparam int DEF_WINDOW = 32;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int SUM_OUT_W  = 21;
  localparam int MEAN_W     = 16;
  localparam int CNT_OUT_W  = 6;

  // Input and output stream widths (fields packed, padded to bytes)
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 80;

  // Largest sample value, start value of the running minimum
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

endpackage

// File: design/swmma_ram.sv
// ---------------------------------------------------------------------------
// swmma_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module swmma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sliding_window_min_max_average.sv
// ---------------------------------------------------------------------------
// sliding_window_min_max_average
// Sum, minimum, maximum and mean over the last WINDOW samples of a stream.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one 16-bit unsigned sample per item. The sample is stored in a
//           circular history RAM of WINDOW entries.
//   out_* : one result item per sample: sum, min and max over the samples
//           stored so far (at most WINDOW), the mean (sum / WINDOW, floor,
//           always by the full WINDOW) and the number of samples included.
// Timing:
//   After an item is accepted the block walks the history through the RAM
//   read port, one entry per cycle, newest first, then the mean is formed
//   in the last walk cycle by a multiply with the constant reciprocal of
//   WINDOW. The result is loaded into the output register from the done
//   state, and the next item can be taken once the block is back in idle;
//   in_tready is high only between items. The RAM read port sets the pace.
// Stall:
//   The result sits in an output register; the next sample is accepted
//   while it waits. A new result waits in turn until the register is free.
// Reset:
//   Pointer, fill count and handshake state are cleared; the history RAM is
//   not, and entries are only ever read after being written.
// ---------------------------------------------------------------------------
`include "sliding_window_min_max_average_assert.svh"

module sliding_window_min_max_average #(
  parameter int WINDOW = swmma_pkg::DEF_WINDOW
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [15:0] sample_value
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [swmma_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: [20:0] window_sum, [36:21] window_min, [52:37] window_max,
  //            [68:53] window_mean, [74:69] valid_entries, [79:75] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [swmma_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import swmma_pkg::*;

  localparam int AW    = $clog2(WINDOW);
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int SUM_W = $clog2(WINDOW * 65535 + 1);
  // Mean by reciprocal multiplication, exact floor for any sum below 2^SUM_W
  localparam int RS    = SUM_W + $clog2(WINDOW);
  localparam int RW    = SUM_W + 1;
  localparam int PW    = SUM_W + RW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RS) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_t;

  // Control registers
  state_t          state_r, state_nxt;
  logic [AW-1:0]   wptr_r, wptr_nxt;
  logic [AW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  logic            dvld_r, dvld_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic [SAMPLE_W-1:0] hi_r, hi_nxt;
  logic [MEAN_W-1:0]   quo_r, quo_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                in_acc;
  logic [SAMPLE_W-1:0] rd_data;
  logic [PW-1:0]       mean_prod;
  logic [SUM_W+SUM_OUT_W-1:0] sum_ext;
  logic [CW+CNT_OUT_W-1:0]    cnt_ext;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // History RAM
  swmma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wptr_r),
    .wdata (in_tdata[SAMPLE_W-1:0]),
    .raddr (rptr_r),
    .rdata (rd_data)
  );

  // Sum times the reciprocal of the window size
  assign mean_prod = PW'(sum_r) * PW'(RECIP);
  // Output widths through zero-extended copies, then truncated
  assign sum_ext = {{SUM_OUT_W{1'b0}}, sum_r};
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, fill_r};

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    fill_nxt      = fill_r;
    left_nxt      = left_r;
    dvld_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    sum_nxt       = sum_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    quo_nxt       = quo_r;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // Store sample, walk starts at the newest entry
          rptr_nxt = wptr_r;
          wptr_nxt = (wptr_r == AW'(WINDOW - 1)) ? '0 : wptr_r + 1'b1;
          fill_nxt = (fill_r == CW'(WINDOW)) ? fill_r : fill_r + 1'b1;
          left_nxt = fill_nxt;
          sum_nxt  = '0;
          lo_nxt   = SAMPLE_MAX;
          hi_nxt   = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // Issue one read per cycle, going back in time
        if (left_r != '0) begin
          left_nxt = left_r - 1'b1;
          rptr_nxt = (rptr_r == '0) ? AW'(WINDOW - 1) : rptr_r - 1'b1;
          dvld_nxt = 1'b1;
        end
        // Fold in the entry read last cycle
        if (dvld_r) begin
          sum_nxt = sum_r + SUM_W'(rd_data);
          if (rd_data < lo_r) lo_nxt = rd_data;
          if (rd_data > hi_r) hi_nxt = rd_data;
        end
        // Walk done: take the mean from the final sum
        if ((left_r == '0) && !dvld_r) begin
          quo_nxt   = mean_prod[RS +: MEAN_W];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Load the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, cnt_ext[CNT_OUT_W-1:0], quo_r, hi_r, lo_r,
                           sum_ext[SUM_OUT_W-1:0]};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wptr_r      <= '0;
      rptr_r      <= '0;
      fill_r      <= '0;
      left_r      <= '0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      fill_r      <= fill_nxt;
      left_r      <= left_nxt;
      dvld_r      <= dvld_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    quo_r <= quo_nxt;
  end

  // Checks
  `SWMMA_ASSERT(a_fill_range, (fill_r <= CW'(WINDOW)), "fill count above window size")
  `SWMMA_ASSERT(a_wptr_range, (32'(wptr_r) < WINDOW), "write pointer out of range")
  `SWMMA_ASSERT_NEXT(a_walk_len, in_acc, (left_r == fill_r) && (state_r == ST_WALK), "walk length differs from fill count")
  `SWMMA_ASSERT_IMP(a_dvld_walk, dvld_r, (state_r == ST_WALK), "read data returned outside walk")
  `SWMMA_ASSERT_IMP(a_out_load, $rose(out_valid_r), $past(state_r == ST_DONE), "result loaded without finished item")

endmodule

// File: bench/sliding_window_min_max_average_checker.sv
// ----------------------------------------------------------------------------
// Window statistics checker
// Watches both stream channels of the sliding window block. Every accepted
// sample updates a private copy of the history and yields the expected sum,
// min, max, mean and entry count; every accepted result is compared field by
// field with the oldest expected one.
// ----------------------------------------------------------------------------
module sliding_window_min_max_average_checker #(
  parameter int WINDOW = swmma_pkg::DEF_WINDOW
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [swmma_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [swmma_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                                mismatch_count,
  output int                                results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import swmma_pkg::*;

  // Result fields, lowest bits last (sum sits at bit 0)
  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    logic [MEAN_W-1:0]    mean;
    logic [SAMPLE_W-1:0]  max;
    logic [SAMPLE_W-1:0]  min;
    logic [SUM_OUT_W-1:0] sum;
  } window_stats_t;

  localparam int STATS_W = $bits(window_stats_t);

  // Private copy of the block state
  logic [SAMPLE_W-1:0] history [WINDOW];
  int                  wr_ptr;
  int                  fill;
  window_stats_t       stats_queue [$];
  int                  result_index;

  // Store one sample and walk back over the filled part of the window
  function automatic window_stats_t update_window(logic [SAMPLE_W-1:0] sample);
    window_stats_t       s;
    logic [31:0]         total;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] v;
    int                  slot;
    history[wr_ptr] = sample;
    if (fill < WINDOW) fill++;
    total = '0;
    lo    = SAMPLE_MAX;
    hi    = '0;
    slot  = wr_ptr;
    for (int k = 0; k < fill; k++) begin
      v     = history[slot];
      total = total + 32'(v);
      if (v < lo) lo = v;
      if (v > hi) hi = v;
      slot = (slot == 0) ? WINDOW - 1 : slot - 1;
    end
    wr_ptr  = (wr_ptr == WINDOW - 1) ? 0 : wr_ptr + 1;
    s.sum   = total[SUM_OUT_W-1:0];
    s.min   = lo;
    s.max   = hi;
    // mean divides by the full window, even while filling
    s.mean  = MEAN_W'(total / 32'(WINDOW));
    s.count = CNT_OUT_W'(fill);
    return s;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (mismatch_count < 10)
        $display("[%0t] result %0d: %s expected %0d, got %0d",
                 $realtime, result_index, name, want, got);
      mismatch_count++;
    end
  endtask

  // Pop and compare first, then queue the prediction for a new sample
  always @(posedge clk) begin
    window_stats_t got;
    window_stats_t want;
    if (!rst_n) begin
      wr_ptr         = 0;
      fill           = 0;
      result_index   = 0;
      mismatch_count = 0;
      stats_queue.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = window_stats_t'(out_tdata[STATS_W-1:0]);
        if (stats_queue.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] result %0d arrived with no sample outstanding: %h",
                     $realtime, result_index, out_tdata);
          mismatch_count++;
        end else begin
          want = stats_queue.pop_front();
          check_field("window_sum", 32'(want.sum), 32'(got.sum));
          check_field("window_min", 32'(want.min), 32'(got.min));
          check_field("window_max", 32'(want.max), 32'(got.max));
          check_field("window_mean", 32'(want.mean), 32'(got.mean));
          check_field("valid_entries", 32'(want.count), 32'(got.count));
          check_field("padding", 32'd0, 32'(out_tdata[OUT_TDATA_W-1:STATS_W]));
        end
        result_index++;
      end
      if (in_tvalid && in_tready)
        stats_queue.push_back(update_window(in_tdata[SAMPLE_W-1:0]));
    end
    results_pending <= stats_queue.size();
  end

endmodule

// File: bench/sliding_window_min_max_average_tb.sv
// ----------------------------------------------------------------------------
// Sliding window min/max/average testbench
// Drives samples into the block with random gaps on the input side and random
// back-pressure on the result side, including one long receiver hold-off.
// A directed run of edge values comes first, then random bursts of uniform,
// full-scale, near-full-scale, tiny and one-hot samples. The checker module
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module sliding_window_min_max_average_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swmma_pkg::*;

  localparam int WINDOW       = DEF_WINDOW;
  localparam int RANDOM_ITEMS = 1800;
  localparam int LONG_HOLD    = 700;
  localparam int IDLE_LIMIT   = 4000;

  typedef enum int {
    MODE_UNIFORM,
    MODE_TOP,
    MODE_NEAR_TOP,
    MODE_LOW,
    MODE_ONEHOT
  } sample_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [15:0] sample_value
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // sum, min, max, mean, valid_entries, zero
  int                     mismatch_count;
  int                     results_pending;
  int                     idle_cycles;

  sliding_window_min_max_average #(.WINDOW(WINDOW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sliding_window_min_max_average_checker #(.WINDOW(WINDOW)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [SAMPLE_W-1:0] make_sample(sample_mode_t mode);
    case (mode)
      MODE_TOP:      return SAMPLE_MAX;
      MODE_NEAR_TOP: return SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 3));
      MODE_LOW:      return SAMPLE_W'($urandom_range(0, 3));
      MODE_ONEHOT:   return SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
      default:       return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one item, hold it until accepted, then idle for the given gap
  task automatic drive_sample(logic [SAMPLE_W-1:0] sample, int gap);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(sample);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // Sender: reset, directed edge values, random bursts, verdict
  initial begin
    logic [SAMPLE_W-1:0] directed [$];
    sample_mode_t        mode;
    int                  sent;
    int                  burst;
    int                  r;
    bit                  no_idle;
    bit                  paused_mid;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Edge values while the window fills: extremes, bit patterns, ties
    directed = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hAAAA, 16'h5555,
                 16'h00FF, 16'hFF00, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001,
                 16'hFFFE, 16'h7FFF, 16'd12345, 16'd12345, 16'd60, 16'd59,
                 16'd61, 16'd30, 16'd144, 16'h0100, 16'h1000, 16'hFFFF};
    foreach (directed[i])
      drive_sample(directed[i], (i < 12) ? 0 : pick_gap());
    wait_drained();

    // Random bursts; the window wraps many times over
    sent       = 0;
    paused_mid = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 40)      mode = MODE_UNIFORM;
      else if (r < 55) mode = MODE_TOP;
      else if (r < 70) mode = MODE_NEAR_TOP;
      else if (r < 85) mode = MODE_LOW;
      else             mode = MODE_ONEHOT;
      no_idle = ($urandom_range(0, 3) == 0);
      burst   = $urandom_range(8, 64);
      repeat (burst) begin
        drive_sample(make_sample(mode), no_idle ? 0 : pick_gap());
        sent++;
      end
      // one full pause midway until every result is back
      if (!paused_mid && sent >= RANDOM_ITEMS / 2) begin
        paused_mid = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (WINDOW + 40) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random back-pressure with one long hold-off
  initial begin
    int loops;
    int stall;
    out_tready <= 1'b0;
    loops = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      loops++;
      if (loops == 40) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 300 : 40)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
